// ----- hw/rtl/virtqueue_descriptor_ring_engine_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the virtqueue descriptor ring engine
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef VIRTQUEUE_DESCRIPTOR_RING_ENGINE_CORE_DEFINES_SVH
`define VIRTQUEUE_DESCRIPTOR_RING_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define VDRE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vdre assertion failed");

// next-cycle implication
`define VDRE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vdre assertion failed");

`endif

// ----- hw/rtl/vdre_pkg.sv -----
// ----------------------------------------------------------------------------
// vdre_pkg
// Types, operation codes and helpers shared by the descriptor ring engine.
// ----------------------------------------------------------------------------
package vdre_pkg;

  localparam int unsigned MAX_QUEUE_LEN_DEF = 256;
  localparam logic [8:0]  QUEUE_LEN_RESET   = 9'd256;

  // operation codes carried by the kind field
  localparam logic [2:0] KIND_INIT         = 3'd0;
  localparam logic [2:0] KIND_ADD_AVAIL    = 3'd1;
  localparam logic [2:0] KIND_GET_USED     = 3'd2;
  localparam logic [2:0] KIND_GATHER_USED  = 3'd3;
  localparam logic [2:0] KIND_GET_AVAIL    = 3'd4;
  localparam logic [2:0] KIND_ADD_USED     = 3'd5;
  localparam logic [2:0] KIND_GATHER_AVAIL = 3'd6;

  // one classified transaction handed from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic [8:0]  first;
    logic [8:0]  cur;
    logic [63:0] addr;
    logic [31:0] len;
    logic [15:0] flags;
    logic [8:0]  n;
    logic        first_ok;
    logic        cur_ok;
  } op_t;

  // effective queue length: zero reads as one, saturate at the table depth
  function automatic logic [8:0] eff_len(input logic [8:0] ql, input int unsigned maxl);
    logic [8:0] r;
    if (ql == 9'd0) begin
      r = 9'd1;
    end else if (32'(ql) > maxl) begin
      r = 9'(maxl);
    end else begin
      r = ql;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/vdre_front.sv -----
// ----------------------------------------------------------------------------
// vdre_front
// Accepts transactions, classifies indices against the queue length and
// holds them in a two-entry queue for the execution back end.
// ----------------------------------------------------------------------------
`include "virtqueue_descriptor_ring_engine_core_defines.svh"

module vdre_front import vdre_pkg::*; #(
  parameter int unsigned MAX_QUEUE_LEN = MAX_QUEUE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [8:0]  in_chain_first,
  input  logic [8:0]  in_chain_cur,
  input  logic [63:0] in_buffer_address,
  input  logic [31:0] in_buffer_length,
  input  logic [15:0] in_buffer_flags,
  input  logic [8:0]  queue_length,
  input  logic        pop,
  output logic        not_empty,
  output op_t         head
);

  op_t        q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  op_t        op_in;
  logic [8:0] n;
  logic       push;

  // classify the incoming transaction
  always_comb begin
    n              = eff_len(queue_length, MAX_QUEUE_LEN);
    op_in.kind     = in_kind;
    op_in.first    = in_chain_first;
    op_in.cur      = in_chain_cur;
    op_in.addr     = in_buffer_address;
    op_in.len      = in_buffer_length;
    op_in.flags    = in_buffer_flags;
    op_in.n        = n;
    op_in.first_ok = (in_chain_first < n);
    op_in.cur_ok   = (in_chain_cur < n);
  end

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign not_empty = (cnt_r != 2'd0);
  assign head      = q_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= op_in;
    end
  end

  `VDRE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= 2'd2)
  `VDRE_ASSERT_IMP(a_pop_nonempty, pop, cnt_r != 2'd0)
  `VDRE_ASSERT_NXT(a_push_grows, push && !pop, cnt_r == 2'($past(cnt_r) + 2'd1))

endmodule

// ----- hw/rtl/vdre_back.sv -----
// ----------------------------------------------------------------------------
// vdre_back
// Executes queued transactions against the descriptor table, free list and
// rings: read in the issue cycle, compute and write in the execute cycle.
// After reset and after an init, a clearing pass rewrites every descriptor
// (fields zero, link own index plus one).
// ----------------------------------------------------------------------------
`include "virtqueue_descriptor_ring_engine_core_defines.svh"

module vdre_back import vdre_pkg::*; #(
  parameter int unsigned MAX_QUEUE_LEN = MAX_QUEUE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        not_empty,
  input  op_t         head,
  output logic        pop,
  output logic        out_valid,
  output logic        out_ok,
  output logic [8:0]  out_new_first,
  output logic [8:0]  out_new_cur,
  output logic [63:0] out_address,
  output logic [31:0] out_length,
  output logic [15:0] out_flags
);

  localparam int unsigned AW     = $clog2(MAX_QUEUE_LEN);
  localparam int unsigned DESC_W = 112;
  localparam int unsigned USED_W = 41;
  localparam logic [8:0]  RST_N  = eff_len(QUEUE_LEN_RESET, MAX_QUEUE_LEN);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_LINK  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r;

  // memories
  logic [DESC_W-1:0] desc_mem  [MAX_QUEUE_LEN];
  logic [8:0]        link_mem  [MAX_QUEUE_LEN];
  logic [8:0]        avail_mem [MAX_QUEUE_LEN];
  logic [USED_W-1:0] used_mem  [MAX_QUEUE_LEN];

  logic [DESC_W-1:0] desc_q;
  logic [8:0]        link_q, avail_q;
  logic [USED_W-1:0] used_q;
  logic [8:0]        rd_idx;
  logic [8:0]        mask_h;
  logic [AW-1:0]     avail_ra, used_ra;

  logic [AW-1:0] clr_r, clr_nxt;

  logic [8:0] free_head_r, free_head_nxt;
  logic [8:0] avail_wr_r, avail_wr_nxt, avail_rd_r, avail_rd_nxt;
  logic [8:0] used_wr_r, used_wr_nxt, used_rd_r, used_rd_nxt;

  // result registers
  logic        out_valid_r, out_valid_nxt;
  logic        ok_r, ok_nxt;
  logic [8:0]  first_r, first_nxt, cur_r, cur_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [31:0] len_r, len_nxt;
  logic [15:0] flags_r, flags_nxt;

  // write controls
  logic              desc_we, link_we, avail_we, used_we;
  logic [AW-1:0]     desc_wa, link_wa, avail_wa, used_wa;
  logic [DESC_W-1:0] desc_wd;
  logic [8:0]        link_wd;
  logic [8:0]        mask, nxt_pos, lnext;
  logic [63:0]       d_addr;
  logic [31:0]       d_len;
  logic [15:0]       d_flags;

  assign pop = (state_r == S_IDLE) && not_empty;

  // read address issue
  always_comb begin
    mask_h   = 9'(head.n - 9'd1);
    rd_idx   = (head.kind == KIND_ADD_AVAIL) ? free_head_r : head.cur;
    avail_ra = AW'(9'(avail_rd_r + 9'd1) & mask_h);
    used_ra  = AW'(9'(used_rd_r + 9'd1) & mask_h);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r     <= head;
      desc_q   <= desc_mem[AW'(rd_idx)];
      link_q   <= link_mem[AW'(rd_idx)];
      avail_q  <= avail_mem[avail_ra];
      used_q   <= used_mem[used_ra];
    end
  end

  // execute
  always_comb begin
    mask    = 9'(op_r.n - 9'd1);
    d_addr  = desc_q[111:48];
    d_len   = desc_q[47:16];
    d_flags = desc_q[15:0];
    lnext   = link_q;
    nxt_pos = 9'd0;

    state_nxt     = state_r;
    clr_nxt       = clr_r;
    free_head_nxt = free_head_r;
    avail_wr_nxt  = avail_wr_r;
    avail_rd_nxt  = avail_rd_r;
    used_wr_nxt   = used_wr_r;
    used_rd_nxt   = used_rd_r;
    out_valid_nxt = 1'b0;
    ok_nxt        = ok_r;
    first_nxt     = first_r;
    cur_nxt       = cur_r;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    flags_nxt     = flags_r;

    desc_we   = 1'b0;
    link_we   = 1'b0;
    avail_we  = 1'b0;
    used_we   = 1'b0;
    desc_wa   = AW'(free_head_r);
    desc_wd   = {op_r.addr, op_r.len, op_r.flags};
    link_wa   = AW'(free_head_r);
    link_wd   = op_r.n;
    avail_wa  = AW'(avail_wr_r & mask);
    used_wa   = AW'(used_wr_r & mask);

    case (state_r)
      S_IDLE: begin
        if (pop) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ok_nxt        = 1'b0;
        first_nxt     = op_r.first;
        cur_nxt       = op_r.cur;
        addr_nxt      = 64'd0;
        len_nxt       = 32'd0;
        flags_nxt     = 16'd0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (op_r.kind)
          KIND_INIT: begin
            // answer now, then rewrite the table before the next transaction
            state_nxt     = S_CLEAR;
            clr_nxt       = '0;
            free_head_nxt = 9'd0;
            avail_wr_nxt  = 9'd0;
            used_wr_nxt   = 9'd0;
            avail_rd_nxt  = mask;
            used_rd_nxt   = mask;
            ok_nxt        = 1'b1;
          end
          KIND_ADD_AVAIL: begin
            if (free_head_r < op_r.n) begin
              free_head_nxt = lnext;
              desc_we       = 1'b1;
              link_we       = 1'b1;
              cur_nxt       = free_head_r;
              ok_nxt        = 1'b1;
              if (!op_r.first_ok) begin
                first_nxt    = free_head_r;
                avail_we     = 1'b1;
                avail_wr_nxt = 9'(avail_wr_r + 9'd1) & mask;
              end
              // chain onto the caller's tail in a second link write
              if (op_r.cur_ok) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_LINK;
              end
            end
          end
          KIND_GET_USED: begin
            nxt_pos = 9'(used_rd_r + 9'd1) & mask;
            if (nxt_pos != (used_wr_r & mask)) begin
              used_rd_nxt = nxt_pos;
              first_nxt   = used_q[40:32];
              cur_nxt     = used_q[40:32];
              len_nxt     = used_q[31:0];
              ok_nxt      = 1'b1;
            end
          end
          KIND_GATHER_USED: begin
            if (op_r.cur_ok) begin
              addr_nxt      = d_addr;
              len_nxt       = d_len;
              flags_nxt     = d_flags;
              link_we       = 1'b1;
              link_wa       = AW'(op_r.cur);
              link_wd       = free_head_r;
              free_head_nxt = op_r.cur;
              cur_nxt       = lnext;
              ok_nxt        = 1'b1;
            end
          end
          KIND_GET_AVAIL: begin
            nxt_pos = 9'(avail_rd_r + 9'd1) & mask;
            if (nxt_pos != (avail_wr_r & mask)) begin
              avail_rd_nxt = nxt_pos;
              first_nxt    = avail_q;
              cur_nxt      = avail_q;
              ok_nxt       = 1'b1;
            end
          end
          KIND_ADD_USED: begin
            used_we     = 1'b1;
            used_wr_nxt = 9'(used_wr_r + 9'd1) & mask;
            ok_nxt      = 1'b1;
          end
          KIND_GATHER_AVAIL: begin
            if (op_r.cur_ok) begin
              addr_nxt  = d_addr;
              len_nxt   = d_len;
              flags_nxt = d_flags;
              cur_nxt   = lnext;
              ok_nxt    = 1'b1;
            end
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end
      S_LINK: begin
        link_we       = 1'b1;
        link_wa       = AW'(op_r.cur);
        link_wd       = cur_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_CLEAR: begin
        // one descriptor per cycle: fields zero, link to the next index
        desc_we = 1'b1;
        desc_wa = clr_r;
        desc_wd = '0;
        link_we = 1'b1;
        link_wa = clr_r;
        link_wd = 9'(clr_r) + 9'd1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_QUEUE_LEN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_head_r <= 9'd0;
      avail_wr_r  <= 9'd0;
      used_wr_r   <= 9'd0;
      avail_rd_r  <= 9'(RST_N - 9'd1);
      used_rd_r   <= 9'(RST_N - 9'd1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      avail_wr_r  <= avail_wr_nxt;
      used_wr_r   <= used_wr_nxt;
      avail_rd_r  <= avail_rd_nxt;
      used_rd_r   <= used_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    first_r <= first_nxt;
    cur_r   <= cur_nxt;
    addr_r  <= addr_nxt;
    len_r   <= len_nxt;
    flags_r <= flags_nxt;
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_wa] <= desc_wd;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (avail_we) begin
      avail_mem[avail_wa] <= free_head_r;
    end
    if (used_we) begin
      used_mem[used_wa] <= {op_r.first, op_r.len};
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = ok_r;
  assign out_new_first = first_r;
  assign out_new_cur   = cur_r;
  assign out_address   = addr_r;
  assign out_length    = len_r;
  assign out_flags     = flags_r;

  `VDRE_ASSERT_NXT(a_pop_exec, pop, state_r == S_EXEC)
  `VDRE_ASSERT_IMP(a_link_after_exec, state_r == S_LINK, $past(state_r) == S_EXEC)
  `VDRE_ASSERT_NXT(a_link_strobe, state_r == S_LINK, out_valid_r)

endmodule

// ----- hw/rtl/virtqueue_descriptor_ring_engine_core.sv -----
// A transaction is taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Each result appears for exactly one
// cycle with out_valid high and cannot be stalled. The execution unit reads
// memory in the issue step, then computes and writes back; an add that links
// onto an existing chain takes a further link write step, since the link
// table has one write port. With an empty queue and an idle execution unit,
// a transaction passes the command queue, issue and result registers before
// out_valid rises. After reset and after every init the execution unit
// rewrites all MAX_QUEUE_LEN descriptor entries (256 by default) before it
// takes the next transaction; the init result itself is returned before that
// pass. Write cfg_wdata (queue length) only while the block is idle.
// ----------------------------------------------------------------------------
// virtqueue_descriptor_ring_engine_core
// Split virtqueue engine: descriptor table, free list, available and used
// rings, with a decoupled command front end and execution back end.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_ring_engine_core import vdre_pkg::*; #(
  parameter int unsigned MAX_QUEUE_LEN = MAX_QUEUE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [8:0]  in_chain_first,
  input  logic [8:0]  in_chain_cur,
  input  logic [63:0] in_buffer_address,
  input  logic [31:0] in_buffer_length,
  input  logic [15:0] in_buffer_flags,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  output logic        out_valid,
  output logic        out_ok,
  output logic [8:0]  out_new_first,
  output logic [8:0]  out_new_cur,
  output logic [63:0] out_address,
  output logic [31:0] out_length,
  output logic [15:0] out_flags
);

  logic [8:0] queue_length_r;
  logic       pop, not_empty;
  op_t        head;

  // queue length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_length_r <= QUEUE_LEN_RESET;
    end else if (cfg_we) begin
      queue_length_r <= cfg_wdata;
    end
  end

  vdre_front #(.MAX_QUEUE_LEN(MAX_QUEUE_LEN)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_chain_first    (in_chain_first),
    .in_chain_cur      (in_chain_cur),
    .in_buffer_address (in_buffer_address),
    .in_buffer_length  (in_buffer_length),
    .in_buffer_flags   (in_buffer_flags),
    .queue_length      (queue_length_r),
    .pop               (pop),
    .not_empty         (not_empty),
    .head              (head)
  );

  vdre_back #(.MAX_QUEUE_LEN(MAX_QUEUE_LEN)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .not_empty     (not_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ok        (out_ok),
    .out_new_first (out_new_first),
    .out_new_cur   (out_new_cur),
    .out_address   (out_address),
    .out_length    (out_length),
    .out_flags     (out_flags)
  );

endmodule

// ----- bench/vdre_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdre_checker
// Watches the command, result and configuration ports of the descriptor ring
// engine, predicts each result from its own copy of the queue state and
// compares it field by field, in order, with what the engine returns.
// ----------------------------------------------------------------------------
module vdre_checker import vdre_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [8:0]  in_chain_first,
  input  logic [8:0]  in_chain_cur,
  input  logic [63:0] in_buffer_address,
  input  logic [31:0] in_buffer_length,
  input  logic [15:0] in_buffer_flags,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        out_valid,
  input  logic        out_ok,
  input  logic [8:0]  out_new_first,
  input  logic [8:0]  out_new_cur,
  input  logic [63:0] out_address,
  input  logic [31:0] out_length,
  input  logic [15:0] out_flags,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic        ok;
    logic [8:0]  first;
    logic [8:0]  cur;
    logic [63:0] addr;
    logic [31:0] len;
    logic [15:0] flags;
  } vq_result_t;

  // shadow queue state
  logic [8:0]  shadow_qlen;
  logic [63:0] sh_desc_addr [256];
  logic [31:0] sh_desc_len  [256];
  logic [15:0] sh_desc_flags[256];
  logic [8:0]  sh_desc_link [256];
  logic [8:0]  sh_free_head;
  logic [7:0]  sh_avail_ids [256];
  logic [8:0]  sh_used_ids  [256];
  logic [31:0] sh_used_lens [256];
  logic [7:0]  sh_avail_wr, sh_used_wr, sh_avail_rd, sh_used_rd;

  vq_result_t expected_results[$];

  function automatic logic [8:0] active_len();
    logic [8:0] n;
    if (shadow_qlen == 9'd0) n = 9'd1;
    else if (shadow_qlen > 9'd256) n = 9'd256;
    else n = shadow_qlen;
    return n;
  endfunction

  function automatic void clear_queue();
    logic [8:0] n;
    n = active_len();
    for (int i = 0; i < 256; i++) begin
      sh_desc_addr[i]  = '0;
      sh_desc_len[i]   = '0;
      sh_desc_flags[i] = '0;
      sh_desc_link[i]  = 9'(i + 1);
    end
    sh_free_head = '0;
    sh_avail_wr  = '0;
    sh_used_wr   = '0;
    sh_avail_rd  = 8'(n - 9'd1);
    sh_used_rd   = 8'(n - 9'd1);
  endfunction

  // one queue operation: update the shadow state, return the answer
  function automatic vq_result_t run_queue_op(
    logic [2:0] kind, logic [8:0] first, logic [8:0] cur,
    logic [63:0] addr, logic [31:0] len, logic [15:0] flags);
    vq_result_t r;
    logic [8:0] n, mask, head, nxt;
    logic [7:0] pos;
    n    = active_len();
    mask = n - 9'd1;
    r    = '0;
    r.first = first;
    r.cur   = cur;
    case (kind)
      KIND_INIT: begin
        clear_queue();
        r.ok = 1'b1;
      end
      KIND_ADD_AVAIL: begin
        head = sh_free_head;
        if (head < n) begin
          sh_free_head        = sh_desc_link[head];
          sh_desc_addr[head]  = addr;
          sh_desc_len[head]   = len;
          sh_desc_flags[head] = flags;
          sh_desc_link[head]  = n;
          if (cur < n) sh_desc_link[cur] = head;
          r.cur = head;
          // new chain: publish its head
          if (first >= n) begin
            r.first = head;
            pos = sh_avail_wr & mask[7:0];
            sh_avail_ids[pos] = head[7:0];
            sh_avail_wr = 8'((9'(sh_avail_wr) + 9'd1) & mask);
          end
          r.ok = 1'b1;
        end
      end
      KIND_GET_USED: begin
        nxt = (9'(sh_used_rd) + 9'd1) & mask;
        if (nxt != (9'(sh_used_wr) & mask)) begin
          sh_used_rd = nxt[7:0];
          r.first = sh_used_ids[nxt[7:0]];
          r.cur   = r.first;
          r.len   = sh_used_lens[nxt[7:0]];
          r.ok    = 1'b1;
        end
      end
      KIND_GATHER_USED: begin
        if (cur < n) begin
          r.addr  = sh_desc_addr[cur];
          r.len   = sh_desc_len[cur];
          r.flags = sh_desc_flags[cur];
          nxt = sh_desc_link[cur];
          sh_desc_link[cur] = sh_free_head;
          sh_free_head = cur;
          r.cur = nxt;
          r.ok  = 1'b1;
        end
      end
      KIND_GET_AVAIL: begin
        nxt = (9'(sh_avail_rd) + 9'd1) & mask;
        if (nxt != (9'(sh_avail_wr) & mask)) begin
          r.first = {1'b0, sh_avail_ids[nxt[7:0]]};
          r.cur   = r.first;
          sh_avail_rd = nxt[7:0];
          r.ok = 1'b1;
        end
      end
      KIND_ADD_USED: begin
        pos = sh_used_wr & mask[7:0];
        sh_used_ids[pos]  = first;
        sh_used_lens[pos] = len;
        sh_used_wr = 8'((9'(sh_used_wr) + 9'd1) & mask);
        r.ok = 1'b1;
      end
      KIND_GATHER_AVAIL: begin
        if (cur < n) begin
          r.addr  = sh_desc_addr[cur];
          r.len   = sh_desc_len[cur];
          r.flags = sh_desc_flags[cur];
          r.cur   = sh_desc_link[cur];
          r.ok    = 1'b1;
        end
      end
      default: ;  // unknown kind: no change, ok low
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count  = 0;
    shadow_qlen = QUEUE_LEN_RESET;
    for (int i = 0; i < 256; i++) begin
      sh_avail_ids[i] = '0;
      sh_used_ids[i]  = '0;
      sh_used_lens[i] = '0;
    end
    clear_queue();
  end

  assign pending_count = expected_results.size();

  // inputs and outputs change only by NBA, so values read here are pre-edge
  always @(posedge clk) begin
    vq_result_t want;
    if (!rst_n) begin
      shadow_qlen = QUEUE_LEN_RESET;
      clear_queue();
      expected_results.delete();
    end else begin
      // compare the returning transaction with the oldest prediction
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result with no transaction outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ok !== want.ok)           report_mismatch("ok", 64'(out_ok), 64'(want.ok));
          if (out_new_first !== want.first) report_mismatch("new_first", 64'(out_new_first),
                                                            64'(want.first));
          if (out_new_cur !== want.cur)     report_mismatch("new_cur", 64'(out_new_cur),
                                                            64'(want.cur));
          if (out_address !== want.addr)    report_mismatch("address", out_address, want.addr);
          if (out_length !== want.len)      report_mismatch("length", 64'(out_length),
                                                            64'(want.len));
          if (out_flags !== want.flags)     report_mismatch("flags", 64'(out_flags),
                                                            64'(want.flags));
        end
      end
      if (start && !busy)
        expected_results.push_back(run_queue_op(in_kind, in_chain_first, in_chain_cur,
                                                in_buffer_address, in_buffer_length,
                                                in_buffer_flags));
      if (cfg_we) shadow_qlen = cfg_wdata;
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random queue transactions into the descriptor ring
// engine across several queue lengths, with bursty pacing; the checker
// predicts and compares every result and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import vdre_pkg::*;

  localparam logic [2:0] KIND_UNKNOWN = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [8:0]  in_chain_first, in_chain_cur;
  logic [63:0] in_buffer_address;
  logic [31:0] in_buffer_length;
  logic [15:0] in_buffer_flags;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;
  logic        out_valid, out_ok;
  logic [8:0]  out_new_first, out_new_cur;
  logic [63:0] out_address;
  logic [31:0] out_length;
  logic [15:0] out_flags;
  int          fail_count, pending_count;

  int         sent_count = 0;
  int         done_count = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  bit         pacing_on = 1'b1;
  logic [8:0] qlen = 9'd256;
  logic [8:0] fb_first = 9'h1FF;
  logic [8:0] fb_cur = 9'h1FF;

  always #1 clk = ~clk;

  virtqueue_descriptor_ring_engine_core u_dut (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_chain_first, .in_chain_cur,
    .in_buffer_address, .in_buffer_length, .in_buffer_flags,
    .cfg_we, .cfg_wdata,
    .out_valid, .out_ok, .out_new_first, .out_new_cur,
    .out_address, .out_length, .out_flags
  );

  vdre_checker u_checker (.*);

  // latch the last answer so chained transactions can follow it
  always @(posedge clk) begin
    if (out_valid) begin
      done_count <= done_count + 1;
      fb_first   <= out_new_first;
      fb_cur     <= out_new_cur;
    end
  end

  // watchdog on cycles with no transaction either way
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_op(logic [2:0] kind, logic [8:0] first, logic [8:0] cur,
                         logic [63:0] addr, logic [31:0] len, logic [15:0] flags);
    int gap;
    // bursty pacing
    if (burst_left == 0) begin
      gap = pacing_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start             <= 1'b1;
    in_kind           <= kind;
    in_chain_first    <= first;
    in_chain_cur      <= cur;
    in_buffer_address <= addr;
    in_buffer_length  <= len;
    in_buffer_flags   <= flags;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (done_count != sent_count) @(posedge clk);
  endtask

  task automatic send_rand_data(logic [2:0] kind, logic [8:0] first, logic [8:0] cur);
    send_op(kind, first, cur, {$urandom, $urandom}, $urandom, 16'($urandom));
  endtask

  // new length, then reinit so ring positions match it
  task automatic set_queue_len(logic [8:0] len);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    qlen = len;
    send_rand_data(KIND_INIT, 9'h1FF, 9'h1FF);
  endtask

  // chained op that follows the previous answer
  task automatic chained_op();
    logic [2:0] kind;
    logic [8:0] first, cur;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) kind = KIND_ADD_AVAIL;
    else if (sel < 45) kind = KIND_GET_AVAIL;
    else if (sel < 62) kind = KIND_GATHER_AVAIL;
    else if (sel < 72) kind = KIND_ADD_USED;
    else if (sel < 82) kind = KIND_GET_USED;
    else kind = KIND_GATHER_USED;
    first = fb_first;
    cur   = fb_cur;
    // start a fresh driver chain now and then
    if (kind == KIND_ADD_AVAIL && $urandom_range(0, 3) == 0) begin
      first = 9'($urandom_range(qlen, 511));
      cur   = 9'($urandom_range(qlen, 511));
    end
    send_rand_data(kind, first, cur);
    drain();
  endtask

  task automatic random_phase(logic [8:0] len, int count);
    set_queue_len(len);
    pacing_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 2)
        send_rand_data(3'($urandom), 9'($urandom), 9'($urandom));
      else
        chained_op();
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_kind           = KIND_INIT;
    in_chain_first    = '0;
    in_chain_cur      = '0;
    in_buffer_address = '0;
    in_buffer_length  = '0;
    in_buffer_flags   = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: build a three-descriptor chain with extreme fields
    send_op(KIND_ADD_AVAIL, 9'h1FF, 9'h1FF, '1, '1, '1);
    send_op(KIND_ADD_AVAIL, 9'd0, 9'd0, '0, '0, '0);
    send_op(KIND_ADD_AVAIL, 9'd0, 9'd1, 64'hA5A5_5A5A_0F0F_F0F0, 32'h8000_0001, 16'h8001);
    send_op(KIND_GET_AVAIL, 9'd0, 9'd0, '0, '0, '0);
    send_op(KIND_GATHER_AVAIL, 9'd0, 9'd0, '0, '0, '0);
    send_op(KIND_GATHER_AVAIL, 9'd0, 9'd1, '0, '0, '0);
    send_op(KIND_GATHER_AVAIL, 9'd0, 9'd2, '0, '0, '0);
    send_op(KIND_GATHER_AVAIL, 9'd0, 9'd256, '0, '0, '0);   // no descriptor
    send_op(KIND_GET_AVAIL, 9'd0, 9'd0, '0, '0, '0);        // ring empty
    send_op(KIND_ADD_USED, 9'd0, 9'd0, '0, '1, '0);
    send_op(KIND_GET_USED, 9'd5, 9'd5, '0, '0, '0);
    send_op(KIND_GET_USED, 9'd5, 9'd5, '0, '0, '0);         // ring empty
    send_op(KIND_GATHER_USED, 9'd0, 9'd0, '0, '0, '0);
    send_op(KIND_GATHER_USED, 9'd0, 9'd1, '0, '0, '0);
    send_op(KIND_GATHER_USED, 9'd0, 9'd2, '0, '0, '0);
    send_op(KIND_GATHER_USED, 9'h1FF, 9'h1FF, '0, '0, '0);  // no descriptor
    send_op(KIND_UNKNOWN, 9'h1FF, 9'h0AA, '1, '1, '1);
    send_op(KIND_ADD_USED, 9'h1FF, 9'h155, '1, 32'd7, '1);  // stale index on ring
    send_op(KIND_GET_USED, 9'd0, 9'd0, '0, '0, '0);
    send_op(KIND_GATHER_USED, 9'd0, 9'h1FF, '0, '0, '0);

    // single-entry queue: second add finds the free list exhausted
    set_queue_len(9'd1);
    send_op(KIND_ADD_AVAIL, 9'd1, 9'd1, 64'd1, 32'd1, 16'd1);
    send_op(KIND_ADD_AVAIL, 9'd1, 9'd1, 64'd2, 32'd2, 16'd2);
    send_op(KIND_ADD_USED, 9'd0, 9'd0, '0, 32'd9, '0);
    send_op(KIND_GET_USED, 9'd0, 9'd0, '0, '0, '0);

    // random phases over several lengths, extremes included
    random_phase(9'd4, 60);
    random_phase(9'd256, 60);
    random_phase(9'd0, 25);      // zero reads as one
    random_phase(9'd2, 45);
    random_phase(9'd3, 45);      // not a power of two
    random_phase(9'd300, 35);    // saturates to full depth
    random_phase(9'd8, 60);
    random_phase(9'd511, 25);
    random_phase(9'd16, 60);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
